[rtl/fcdl_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the circular delay line FIR filter.
package fcdl_pkg;

  // Tap count (1 to 8) and the field widths.
  localparam int Taps     = 8;
  localparam int PosW     = (Taps > 1) ? $clog2(Taps) : 1;
  localparam int DataW    = 16;
  localparam int CoefW    = 16;
  localparam int NumCoef  = 8;
  localparam int CoefIdxW = 3;
  localparam int CfgIdxW  = 4;
  localparam int ProdW    = DataW + CoefW;
  localparam int AccW     = ProdW + PosW;

  // Reset value of the coefficient that weights the newest sample.
  localparam logic [CoefW-1:0] CoefNewestReset = 16'h7fff;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDrain,
    StOut
  } fcdl_state_e;

endpackage

[rtl/fir_filter_circular_delay_line.sv]
`timescale 1ns / 1ps
// Direct-form FIR filter over a circular delay line held in a small RAM.
// It works on one item at a time: a new item is accepted only in idle, after the last result
// has been loaded into the output register, since every tap goes through the single
// shared multiply-accumulate unit and the one read port of the delay-line RAM.
// Reset: coefficients pass only the newest sample, scaled by just under one, the delay
// line reads as zero through per-entry valid bits, and the write position returns to zero.
module fir_filter_circular_delay_line (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [fcdl_pkg::DataW-1:0]  sample_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [fcdl_pkg::DataW-1:0]  sample_out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fcdl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [fcdl_pkg::CoefW-1:0]         cfg_data_i
);

  localparam int PosW  = fcdl_pkg::PosW;
  localparam int DataW = fcdl_pkg::DataW;
  localparam int ProdW = fcdl_pkg::ProdW;
  localparam int AccW  = fcdl_pkg::AccW;
  localparam int ShW   = AccW - (DataW - 1);

  fcdl_pkg::fcdl_state_e state_q, state_d;

  logic [fcdl_pkg::CoefW-1:0] coef_q [fcdl_pkg::NumCoef];
  logic [fcdl_pkg::Taps-1:0]  vld_q, vld_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [PosW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [PosW-1:0]            k_q, k_d;

  logic                       s1_vld_q;
  logic                       s1_hit_q;
  logic [PosW-1:0]            s1_k_q;
  logic                       s2_vld_q;
  logic signed [ProdW-1:0]    prod_q, prod_d;
  logic signed [AccW-1:0]     acc_q, acc_d;
  logic signed [DataW-1:0]    out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       ram_we, ram_re;
  logic [DataW-1:0]           ram_rdata;
  logic                       in_fire, out_load;
  logic signed [ShW-1:0]      shifted;
  logic                       no_ovf;
  logic signed [DataW-1:0]    sample_rd;

  function automatic logic [PosW-1:0] pos_wrap(input logic [PosW-1:0] p);
    if (p >= PosW'(fcdl_pkg::Taps - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  fcdl_ram #(
    .Width(DataW),
    .Depth(fcdl_pkg::Taps)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(sample_in_i),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // Control: write the new sample, then walk the line oldest first.
  always_comb begin
    state_d  = state_q;
    vld_d    = vld_q;
    pos_d    = pos_q;
    rd_ptr_d = rd_ptr_q;
    k_d      = k_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    in_ready_o = 1'b0;
    in_fire  = 1'b0;
    case (state_q)
      fcdl_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_fire       = 1'b1;
          ram_we        = 1'b1;
          vld_d[pos_q]  = 1'b1;
          pos_d         = pos_wrap(pos_q);
          rd_ptr_d      = pos_wrap(pos_q);
          k_d           = '0;
          state_d       = fcdl_pkg::StRead;
        end
      end
      fcdl_pkg::StRead: begin
        ram_re   = 1'b1;
        rd_ptr_d = pos_wrap(rd_ptr_q);
        k_d      = k_q + 1'b1;
        if (k_q == PosW'(fcdl_pkg::Taps - 1)) begin
          state_d = fcdl_pkg::StDrain;
        end
      end
      fcdl_pkg::StDrain: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = fcdl_pkg::StOut;
        end
      end
      fcdl_pkg::StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fcdl_pkg::StIdle;
        end
      end
      default: begin
        state_d = fcdl_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcdl_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: an entry never written reads as zero.
  assign sample_rd = s1_hit_q ? $signed(ram_rdata) : '0;
  assign prod_d    = $signed(coef_q[fcdl_pkg::CoefIdxW'(s1_k_q)]) * sample_rd;
  assign acc_d     = in_fire ? '0 :
                     (s2_vld_q ? acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q} : acc_q);

  // Floor shift by 15; the result fits when the bits above the sign agree.
  assign shifted = acc_q[AccW-1:DataW-1];
  assign no_ovf  = (&shifted[ShW-1:DataW-1]) || !(|shifted[ShW-1:DataW-1]);
  assign out_d   = no_ovf ? shifted[DataW-1:0] :
                   (shifted[ShW-1] ? {1'b1, {(DataW - 1){1'b0}}} : {1'b0, {(DataW - 1){1'b1}}});

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      pos_q       <= '0;
      rd_ptr_q    <= '0;
      k_q         <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < fcdl_pkg::NumCoef; i++) begin
        coef_q[i] <= (i == fcdl_pkg::NumCoef - 1) ? fcdl_pkg::CoefNewestReset : '0;
      end
    end else begin
      vld_q       <= vld_d;
      pos_q       <= pos_d;
      rd_ptr_q    <= rd_ptr_d;
      k_q         <= k_d;
      s1_vld_q    <= ram_re;
      s2_vld_q    <= s1_vld_q;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && (cfg_index_i < fcdl_pkg::CfgIdxW'(fcdl_pkg::NumCoef))) begin
        coef_q[fcdl_pkg::CoefIdxW'(cfg_index_i)] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hit_q <= vld_q[rd_ptr_q];
    s1_k_q   <= k_q;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

[rtl/fcdl_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module fcdl_ram #(
  parameter int Width = 16,
  parameter int Depth = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fcdl_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the FIR filter and its bind to the top level.
module fcdl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [fcdl_pkg::DataW-1:0] sample_out_o,
  input logic                             cfg_ready_o
);

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output item changed or dropped");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input accepted while an item is in progress");

  // A new result is published as the block returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result published while still busy");

  // Configuration writes are always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind fir_filter_circular_delay_line fcdl_checker u_fcdl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_out_o(sample_out_o),
  .cfg_ready_o (cfg_ready_o)
);

[tb/sv/fir_filter_circular_delay_line_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the circular delay line FIR filter, predicting each output sample.
module fir_filter_circular_delay_line_test;
  import fcdl_pkg::*;

  localparam int ClkHalf      = 10;
  localparam int ResetCycles  = 7;
  localparam int MaxIdle      = 18;
  localparam int SettleCycles = 2 * (Taps + 5);
  localparam int StallLimit   = 2000;
  localparam int LongHold     = 300;
  localparam int PhaseItems   = 150;
  localparam int NumPhases    = 7;
  localparam int MaxReports   = 10;

  localparam logic [CfgIdxW-1:0] IdxUnusedFirst = CfgIdxW'(NumCoef);
  localparam logic [CfgIdxW-1:0] IdxUnusedLast  = '1;

  localparam logic signed [DataW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [DataW-1:0] SampleMin = 16'sh8000;
  localparam logic signed [CoefW-1:0] CoefMax   = 16'sh7fff;
  localparam logic signed [CoefW-1:0] CoefMin   = 16'sh8000;

  typedef enum int {
    CoefFullRandom,
    CoefModerate,
    CoefShortFilter,
    CoefExtremes,
    CoefAllZero
  } coef_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [DataW-1:0]    sample_in_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [DataW-1:0]    sample_out_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i;
  logic [CoefW-1:0]           cfg_data_i;

  // Predictor state: coefficients, stored samples and the next write slot.
  logic signed [CoefW-1:0]    coef_model [NumCoef];
  logic signed [DataW-1:0]    history [NumCoef];
  int unsigned                write_slot;
  logic signed [CoefW-1:0]    coef_plan [NumCoef];

  logic signed [DataW-1:0]    expected_out [$];
  int                         mismatches   = 0;
  int                         results_seen = 0;
  int                         idle_cycles  = 0;
  int                         hold_request = 0;
  bit                         tx_steady    = 1'b0;
  bit                         rx_steady    = 1'b0;

  fir_filter_circular_delay_line dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Stores the sample, advances the slot and returns the filtered, saturated sum.
  function automatic logic signed [DataW-1:0] filter_sample(input logic signed [DataW-1:0] s);
    longint      acc;
    longint      scaled;
    int unsigned slot;
    history[write_slot % Taps] = s;
    write_slot = (write_slot + 1) % Taps;
    acc = 0;
    for (int k = 0; k < Taps; k++) begin
      slot = (write_slot + k) % Taps;
      acc += longint'(coef_model[k]) * longint'(history[slot]);
    end
    scaled = acc >>> 15;
    if (scaled > 32767) begin
      scaled = 32767;
    end else if (scaled < -32768) begin
      scaled = -32768;
    end
    return scaled[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] pick_sample();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = SampleMax;
      end
      1: begin
        v = SampleMin;
      end
      2: begin
        v = DataW'($urandom_range(0, 511)) - DataW'(256);
      end
      default: begin
        v = DataW'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [CoefW-1:0] moderate_coef();
    return CoefW'($urandom_range(0, 8191)) - CoefW'(4096);
  endfunction

  task automatic note_failure(input string msg);
    if (mismatches < MaxReports) begin
      $display("%s", msg);
    end
    mismatches++;
  endtask

  task automatic send_sample(input logic signed [DataW-1:0] s);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    expected_out.push_back(filter_sample(s));
  endtask

  // Stops offering items and lets the block finish its last result.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumCoef) begin
      coef_model[idx] = data;
    end
    if (last) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  task automatic load_coefs();
    for (int k = 0; k < NumCoef; k++) begin
      write_reg(CfgIdxW'(k), coef_plan[k], k == NumCoef - 1);
    end
  endtask

  // After reset only the newest sample passes, scaled by just under one.
  task automatic test_reset_coefs();
    send_sample(SampleMax);
    send_sample(SampleMin);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    wait_drained();
  endtask

  task automatic test_unused_index();
    write_reg(IdxUnusedFirst, CoefMin, 1'b0);
    write_reg(IdxUnusedLast, 16'h5a5a, 1'b1);
    send_sample(-16'sd12345);
    send_sample(16'sd23456);
    wait_drained();
  endtask

  task automatic test_saturation();
    for (int k = 0; k < NumCoef; k++) begin
      coef_plan[k] = CoefMax;
    end
    load_coefs();
    repeat (4) send_sample(SampleMax);
    wait_drained();
    for (int k = 0; k < NumCoef; k++) begin
      coef_plan[k] = CoefMin;
    end
    load_coefs();
    repeat (3) send_sample(SampleMax);
    repeat (3) send_sample(SampleMin);
    wait_drained();
  endtask

  // The oldest half of the taps is zeroed, as for a four-tap filter.
  task automatic test_short_filter();
    for (int k = 0; k < NumCoef; k++) begin
      coef_plan[k] = (k < NumCoef / 2) ? CoefW'(0) : moderate_coef();
    end
    load_coefs();
    repeat (4) send_sample(pick_sample());
    wait_drained();
  endtask

  // The receiver holds off while items keep coming, then the sender pauses until all results.
  task automatic test_backpressure();
    tx_steady    = 1'b1;
    hold_request = LongHold;
    repeat (24) send_sample(pick_sample());
    wait_drained();
    tx_steady = 1'b0;
    repeat (8) send_sample(pick_sample());
    wait_drained();
  endtask

  task automatic test_random_phases();
    coef_mode_e mode;
    int         zeroed;
    for (int p = 0; p < NumPhases; p++) begin
      mode   = coef_mode_e'(p % 5);
      zeroed = $urandom_range(1, NumCoef - 1);
      for (int k = 0; k < NumCoef; k++) begin
        case (mode)
          CoefFullRandom: begin
            coef_plan[k] = CoefW'($urandom);
          end
          CoefModerate: begin
            coef_plan[k] = moderate_coef();
          end
          CoefShortFilter: begin
            coef_plan[k] = (k < zeroed) ? CoefW'(0) : moderate_coef();
          end
          CoefExtremes: begin
            case ($urandom_range(0, 2))
              0: coef_plan[k] = CoefMax;
              1: coef_plan[k] = CoefMin;
              default: coef_plan[k] = CoefW'(0);
            endcase
          end
          default: begin
            coef_plan[k] = CoefW'(0);
          end
        endcase
      end
      load_coefs();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      repeat (PhaseItems) send_sample(pick_sample());
      wait_drained();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_in_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    for (int k = 0; k < NumCoef; k++) begin
      coef_model[k] = '0;
      history[k]    = '0;
    end
    coef_model[NumCoef-1] = CoefNewestReset;
    write_slot = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_coefs();
    test_unused_index();
    test_saturation();
    test_short_filter();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Output side: a random wait before each item (none when steady), or a long hold when one is requested.
  initial begin : receiver
    int gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, MaxIdle);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && hold_request == 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    logic signed [DataW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        note_failure($sformatf("result %0d: none expected, got %0d", results_seen,
                               sample_out_o));
      end else begin
        want = expected_out.pop_front();
        if (sample_out_o !== want) begin
          note_failure($sformatf("result %0d: expected %0d, got %0d", results_seen, want,
                                 sample_out_o));
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
